// ===== hdl/nps_pkg.sv =====
package nps_pkg;

  // Default table depth
  localparam int unsigned MAX_TASKS_DEF = 16;

  // Field widths
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned ID_W   = 4;
  localparam int unsigned GTIME_W = 32;

  // Input operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_RAN    = 2'd2,
    ST_IDLE   = 2'd3
  } nps_status_t;

  // One task table entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] need;
    logic [TIME_W-1:0] done;
  } nps_rec_t;

endpackage

// ===== hdl/nps_if.sv =====
interface nps_in_if
  import nps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              op;
  logic [PRIO_W-1:0] priority_req;
  logic [TIME_W-1:0] service_time;

  modport source (output valid, output op, output priority_req, output service_time,
                  input ready);
  modport sink   (input valid, input op, input priority_req, input service_time,
                  output ready);
endinterface

interface nps_out_if
  import nps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ID_W-1:0]    task_id;
  logic [PRIO_W-1:0]  task_priority;
  logic [TIME_W-1:0]  task_elapsed;
  logic               task_finished;
  logic [GTIME_W-1:0] global_time;

  modport source (output valid, output status, output task_id, output task_priority,
                  output task_elapsed, output task_finished, output global_time,
                  input ready);
  modport sink   (input valid, input status, input task_id, input task_priority,
                  input task_elapsed, input task_finished, input global_time,
                  output ready);
endinterface

// ===== hdl/nps_table.sv =====
module nps_table
  import nps_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_TASKS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  nps_rec_t      wdata,
  input  logic [AW-1:0] raddr,
  output nps_rec_t      rdata
);

  nps_rec_t mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/nonpreemptive_priority_scheduler.sv =====
// Push: the input word is taken in S_IDLE and the result word is loaded from S_EMIT.
// Tick with a task already running: S_LOAD, S_RUN, then S_EMIT (one table read).
// Tick that must select a task: S_SCAN, S_SCAN_TAIL, S_SCAN_DONE, S_RUN, then S_EMIT (S_RUN is
// skipped when idle); the selection walks every table slot through one comparator, one a cycle.
// Input is ready again the cycle after the result loads; a stalled result holds it off.
// Synchronous reset clears all pending flags, ids, busy and time.
module nonpreemptive_priority_scheduler
  import nps_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  nps_in_if.sink    sched_in,
  nps_out_if.source sched_out
);

  localparam int unsigned SW = $clog2(MAX_TASKS);
  localparam int unsigned NW = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SCAN, S_SCAN_TAIL, S_SCAN_DONE, S_RUN, S_EMIT
  } state_t;

  state_t              state;
  logic [MAX_TASKS-1:0] pending;
  logic [NW-1:0]       next_id;
  logic [SW-1:0]       running_slot;
  logic                busy;
  logic [GTIME_W-1:0]  tick_count;

  // Scan pipeline
  logic [SW-1:0]       scan_addr;
  logic [SW-1:0]       chk_slot;
  logic                chk_valid;
  logic                found;

  // Current task record
  logic [SW-1:0]       cur_slot;
  nps_rec_t            cur_rec;

  // Result staging
  nps_status_t         res_status;
  logic [ID_W-1:0]     res_id;
  logic [PRIO_W-1:0]   res_prio;
  logic [TIME_W-1:0]   res_elapsed;
  logic                res_fin;

  // Table port
  logic                tbl_we;
  logic [SW-1:0]       tbl_waddr;
  nps_rec_t            tbl_wdata;
  logic [SW-1:0]       tbl_raddr;
  nps_rec_t            tbl_rdata;

  logic                in_fire;
  logic                table_full;
  logic [SW-1:0]       push_slot;
  logic [TIME_W-1:0]   done_new;
  logic                run_fin;
  logic                eval_en;
  logic                take_best;
  logic [SW+ID_W-1:0]  push_id_ext;
  logic [SW+ID_W-1:0]  cur_id_ext;
  logic                out_free;

  nps_table #(
    .DEPTH (MAX_TASKS),
    .AW    (SW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign sched_in.ready = (state == S_IDLE);
  assign in_fire        = sched_in.valid && sched_in.ready;
  assign table_full     = (next_id >= NW'(MAX_TASKS));
  assign push_slot      = next_id[SW-1:0];
  assign done_new       = cur_rec.done + TIME_W'(1);
  assign run_fin        = (done_new >= cur_rec.need);
  assign push_id_ext    = {{ID_W{1'b0}}, push_slot};
  assign cur_id_ext     = {{ID_W{1'b0}}, cur_slot};
  assign out_free       = !sched_out.valid || sched_out.ready;

  // Compare the slot returned by the table against the best so far
  assign eval_en   = chk_valid && ((state == S_SCAN) || (state == S_SCAN_TAIL));
  assign take_best = eval_en && pending[chk_slot] && (tbl_rdata.need != '0) &&
                     (!found || (tbl_rdata.prio < cur_rec.prio));

  // Table address and write data
  always_comb begin
    tbl_raddr = (state == S_SCAN) ? scan_addr : running_slot;
    tbl_we    = 1'b0;
    tbl_waddr = push_slot;
    tbl_wdata = '{prio: sched_in.priority_req, need: sched_in.service_time, done: '0};
    if (state == S_RUN) begin
      tbl_we    = 1'b1;
      tbl_waddr = cur_slot;
      tbl_wdata = '{prio: cur_rec.prio, need: cur_rec.need, done: done_new};
    end else if (in_fire && (sched_in.op == OP_PUSH) && !table_full) begin
      tbl_we = 1'b1;
    end
  end

  // Sequencer, scheduler state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pending         <= '0;
      next_id         <= '0;
      running_slot    <= '0;
      busy            <= 1'b0;
      tick_count      <= '0;
      chk_valid       <= 1'b0;
      found           <= 1'b0;
      sched_out.valid <= 1'b0;
    end else begin
      // Drop the output word once taken
      if (sched_out.valid && sched_out.ready && (state != S_EMIT)) begin
        sched_out.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_prio    <= '0;
            res_elapsed <= '0;
            res_fin     <= 1'b0;
            res_id      <= ((sched_in.op == OP_PUSH) && !table_full) ?
                           push_id_ext[ID_W-1:0] : '0;
            if (sched_in.op == OP_PUSH) begin
              if (table_full) begin
                res_status <= ST_FULL;
              end else begin
                res_status         <= ST_PUSHED;
                pending[push_slot] <= 1'b1;
                next_id            <= next_id + NW'(1);
              end
              state <= S_EMIT;
            end else if (busy && pending[running_slot]) begin
              state <= S_LOAD;
            end else begin
              busy      <= 1'b0;
              scan_addr <= '0;
              chk_valid <= 1'b0;
              found     <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end

        S_LOAD: begin
          cur_rec  <= tbl_rdata;
          cur_slot <= running_slot;
          state    <= S_RUN;
        end

        S_SCAN, S_SCAN_TAIL: begin
          // Retire zero-length tasks, keep the best candidate
          if (eval_en && pending[chk_slot] && (tbl_rdata.need == '0)) begin
            pending[chk_slot] <= 1'b0;
          end
          if (take_best) begin
            cur_rec  <= tbl_rdata;
            cur_slot <= chk_slot;
            found    <= 1'b1;
          end
          if (state == S_SCAN) begin
            chk_slot  <= scan_addr;
            chk_valid <= 1'b1;
            scan_addr <= scan_addr + SW'(1);
            if (scan_addr == SW'(MAX_TASKS - 1)) begin
              state <= S_SCAN_TAIL;
            end
          end else begin
            chk_valid <= 1'b0;
            state     <= S_SCAN_DONE;
          end
        end

        S_SCAN_DONE: begin
          if (found) begin
            busy         <= 1'b1;
            running_slot <= cur_slot;
            state        <= S_RUN;
          end else begin
            res_status <= ST_IDLE;
            state      <= S_EMIT;
          end
        end

        S_RUN: begin
          // Run the task one tick and advance time
          tick_count  <= tick_count + GTIME_W'(1);
          res_status  <= ST_RAN;
          res_id      <= cur_id_ext[ID_W-1:0];
          res_prio    <= cur_rec.prio;
          res_elapsed <= done_new;
          res_fin     <= run_fin;
          if (run_fin) begin
            pending[cur_slot] <= 1'b0;
            busy              <= 1'b0;
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            sched_out.valid         <= 1'b1;
            sched_out.status        <= res_status;
            sched_out.task_id       <= res_id;
            sched_out.task_priority <= res_prio;
            sched_out.task_elapsed  <= res_elapsed;
            sched_out.task_finished <= res_fin;
            sched_out.global_time   <= tick_count;
            state                   <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/nps_checker.sv =====
module nps_checker
  import nps_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic [GTIME_W-1:0] global_time
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(global_time))
    else $error("result word changed while stalled");

  // Only one item is worked at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // A result never shows up in the cycle right after an input is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sched_in.valid),
  .in_ready    (sched_in.ready),
  .out_valid   (sched_out.valid),
  .out_ready   (sched_out.ready),
  .status      (sched_out.status),
  .global_time (sched_out.global_time)
);

// ===== sim/nonpreemptive_priority_scheduler_tb.sv =====
`timescale 1ns / 1ps

module nonpreemptive_priority_scheduler_tb;
  import nps_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int GAP_MAX     = 16;

  // One result word as the scheduler should report it
  typedef struct packed {
    nps_status_t        status;
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  elapsed;
    logic               finished;
    logic [GTIME_W-1:0] gtime;
  } sched_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nps_in_if  sched_in_if ();
  nps_out_if sched_out_if ();

  nonpreemptive_priority_scheduler u_dut (
    .clk       (clk),
    .rst       (rst),
    .sched_in  (sched_in_if),
    .sched_out (sched_out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow task table
  logic [PRIO_W-1:0]  tab_prio    [MAX_TASKS_DEF];
  logic [TIME_W-1:0]  tab_need    [MAX_TASKS_DEF];
  logic [TIME_W-1:0]  tab_done    [MAX_TASKS_DEF];
  bit                 tab_pending [MAX_TASKS_DEF];
  int unsigned        push_count;
  int unsigned        cur_slot;
  bit                 task_active;
  logic [GTIME_W-1:0] tick_total = '0;

  sched_word_t awaited_words [$];
  int          mismatch_count;

  bit hold_req;
  bit sink_hold;
  bit src_gapless;
  bit sink_gapless;
  int stall_left;

  // Advance the shadow table by one item and return the word it should produce
  function automatic sched_word_t schedule_item(input logic op, input logic [PRIO_W-1:0] prio,
                                                input logic [TIME_W-1:0] svc);
    sched_word_t w;
    int unsigned best;
    bit found;
    w = '0;
    if (op == OP_PUSH) begin
      if (push_count < MAX_TASKS_DEF) begin
        tab_prio[push_count]    = prio;
        tab_need[push_count]    = svc;
        tab_done[push_count]    = '0;
        tab_pending[push_count] = 1'b1;
        w.status = ST_PUSHED;
        w.id     = push_count[ID_W-1:0];
        push_count++;
      end else begin
        w.status = ST_FULL;
      end
    end else begin
      if (!task_active || !tab_pending[cur_slot])
        task_active = 1'b0;
      // Pick the lowest priority value; earlier slot wins ties; retire empty tasks
      if (!task_active) begin
        found = 1'b0;
        best  = 0;
        for (int unsigned i = 0; i < MAX_TASKS_DEF; i++) begin
          if (tab_pending[i]) begin
            if (tab_need[i] == '0) begin
              tab_pending[i] = 1'b0;
            end else if (!found || tab_prio[i] < tab_prio[best]) begin
              best  = i;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          cur_slot    = best;
          task_active = 1'b1;
        end
      end
      if (!task_active) begin
        w.status = ST_IDLE;
      end else begin
        tab_done[cur_slot] = tab_done[cur_slot] + 1'b1;
        tick_total         = tick_total + 1'b1;
        w.status  = ST_RAN;
        w.id      = cur_slot[ID_W-1:0];
        w.prio    = tab_prio[cur_slot];
        w.elapsed = tab_done[cur_slot];
        if (tab_done[cur_slot] >= tab_need[cur_slot]) begin
          w.finished            = 1'b1;
          tab_pending[cur_slot] = 1'b0;
          task_active           = 1'b0;
        end
      end
    end
    w.gtime = tick_total;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got_v,
                                 input longint unsigned exp_v);
    mismatch_count++;
    $display("%0t: %s got 0x%0h, want 0x%0h", $time, what, got_v, exp_v);
  endtask

  // Compare one accepted word with the oldest pending expectation
  task automatic check_word();
    sched_word_t w;
    if (awaited_words.size() == 0) begin
      report_mismatch("unexpected word, status", sched_out_if.status, 0);
    end else begin
      w = awaited_words.pop_front();
      if (sched_out_if.status !== w.status)
        report_mismatch("status", sched_out_if.status, w.status);
      if (sched_out_if.task_id !== w.id)
        report_mismatch("task_id", sched_out_if.task_id, w.id);
      if (sched_out_if.task_priority !== w.prio)
        report_mismatch("task_priority", sched_out_if.task_priority, w.prio);
      if (sched_out_if.task_elapsed !== w.elapsed)
        report_mismatch("task_elapsed", sched_out_if.task_elapsed, w.elapsed);
      if (sched_out_if.task_finished !== w.finished)
        report_mismatch("task_finished", sched_out_if.task_finished, w.finished);
      if (sched_out_if.global_time !== w.gtime)
        report_mismatch("global_time", sched_out_if.global_time, w.gtime);
    end
  endtask

  // Receiver: check each word, then stall a random number of cycles
  always @(posedge clk) begin
    if (rst) begin
      sched_out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (sched_out_if.valid && sched_out_if.ready) begin
        check_word();
        stall_left = sink_gapless ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (sink_hold) begin
        sched_out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        sched_out_if.ready <= 1'b0;
      end else begin
        sched_out_if.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted here once requested
  initial begin
    @(posedge clk iff hold_req);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // Offer one word after a random gap, hold it until taken, then predict
  task automatic send_item(input logic op, input logic [PRIO_W-1:0] prio,
                           input logic [TIME_W-1:0] svc);
    int gap;
    gap = src_gapless ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      sched_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sched_in_if.valid        <= 1'b1;
    sched_in_if.op           <= op;
    sched_in_if.priority_req <= prio;
    sched_in_if.service_time <= svc;
    do @(posedge clk); while (!sched_in_if.ready);
    awaited_words = {awaited_words, schedule_item(op, prio, svc)};
  endtask

  // Drop valid and wait for every pending word
  task automatic wait_drained();
    sched_in_if.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_after_reset();
    send_item(OP_TICK, 8'h00, 16'h0000);
    send_item(OP_TICK, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_push_and_select();
    send_item(OP_PUSH, 8'hFF, 16'd2);
    // empty task with the best priority: retired at selection, never reported
    send_item(OP_PUSH, 8'h00, 16'd0);
    send_item(OP_PUSH, 8'd7, 16'd3);
    send_item(OP_PUSH, 8'd7, 16'd1);
    // longest task, ties with slot 0 and so runs after it
    send_item(OP_PUSH, 8'hFF, 16'hFFFF);
    send_item(OP_TICK, 8'h5A, 16'hA5A5);
    // arrives mid-run: must wait for the current task to finish
    send_item(OP_PUSH, 8'd1, 16'd1);
    repeat (5) send_item(OP_TICK, 8'h00, 16'h0000);
  endtask

  task automatic test_backpressure_hold();
    hold_req    <= 1'b1;
    src_gapless = 1'b1;
    for (int i = 0; i < 10; i++) begin
      if (i % 3 == 0)
        send_item(OP_PUSH, 8'(3 + i), 16'(1 + i % 4));
      else
        send_item(OP_TICK, 8'($urandom), 16'($urandom));
    end
    src_gapless = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_item(OP_PUSH, 8'd128, 16'd4);
    send_item(OP_TICK, 8'h00, 16'h0000);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items);
    int pct;
    logic op;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] svc;
    for (int i = 0; i < n_items; i++) begin
      // Switch idling pattern on both sides every block of words
      if (i % 125 == 0) begin
        src_gapless  = ($urandom_range(0, 3) == 0);
        sink_gapless <= ($urandom_range(0, 3) == 0);
      end
      pct  = $urandom_range(0, 99);
      prio = PRIO_W'($urandom);
      svc  = TIME_W'($urandom);
      if (push_count < MAX_TASKS_DEF) begin
        op = (pct < 40) ? OP_PUSH : OP_TICK;
        // keep accepted tasks short so the table keeps turning over
        if (op == OP_PUSH)
          svc = TIME_W'($urandom_range(0, 6));
      end else begin
        op = (pct < 20) ? OP_PUSH : OP_TICK;
      end
      send_item(op, prio, svc);
    end
    src_gapless  = 1'b0;
    sink_gapless <= 1'b0;
  endtask

  initial begin
    sched_in_if.valid        <= 1'b0;
    sched_in_if.op           <= OP_TICK;
    sched_in_if.priority_req <= '0;
    sched_in_if.service_time <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_idle_after_reset();
    test_push_and_select();
    test_backpressure_hold();
    test_drain_pause();
    test_random_traffic(1375);

    wait_drained();
    repeat (MAX_TASKS_DEF + 24) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
